/* sv/psfl_pkg.sv */
// ----------------------------------------------------------------------------
// psfl_pkg
// Shared types, constants and the opcode class table of the flood limiter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package psfl_pkg;

    localparam int SLOTS     = 256;
    localparam int CLASSES   = 11;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int BUCKETS   = SLOTS * CLASSES;
    localparam int BKT_AW    = $clog2(BUCKETS);
    localparam int CLS_W     = 4;
    localparam int TOK_W     = 20;

    // slot word: {address, expiry, bucket valid mask}
    localparam int SLOT_WORD_W = 32 + 32 + CLASSES;
    // bucket word: {tokens, last time, flood noted}
    localparam int BKT_WORD_W  = TOK_W + 32 + 1;

    localparam logic [31:0] SWEEP_PERIOD = 32'd720000;
    localparam logic signed [33:0] TOKEN_CAP   = 34'sd60000;
    localparam logic signed [33:0] BAN_LEVEL   = -34'sd180000;
    localparam logic signed [33:0] TOKEN_FLOOR = -34'sd524288;

    typedef enum logic [1:0] {
        VERDICT_ALLOW = 2'd0,
        VERDICT_DROP  = 2'd1,
        VERDICT_BAN   = 2'd2
    } t_verdict;

    typedef struct packed {
        logic             is_req;
        logic [CLS_W-1:0] cls;
        logic [15:0]      cost;
    } t_class;

    function automatic t_class class_of(input logic [7:0] op);
        t_class c;
        c = '{is_req: 1'b1, cls: '0, cost: '0};
        unique case (op)
            8'h01:               begin c.cls = 4'd0;  c.cost = 16'd30000; end
            8'h11:               begin c.cls = 4'd1;  c.cost = 16'd20000; end
            8'h21:               begin c.cls = 4'd2;  c.cost = 16'd6000;  end
            8'h33, 8'h34, 8'h35: begin c.cls = 4'd3;  c.cost = 16'd20000; end
            8'h43:               begin c.cls = 4'd4;  c.cost = 16'd15000; end
            8'h44:               begin c.cls = 4'd5;  c.cost = 16'd20000; end
            8'h45:               begin c.cls = 4'd6;  c.cost = 16'd30000; end
            8'h50, 8'h53:        begin c.cls = 4'd7;  c.cost = 16'd30000; end
            8'h51:               begin c.cls = 4'd8;  c.cost = 16'd30000; end
            8'h52:               begin c.cls = 4'd9;  c.cost = 16'd60000; end
            8'h60:               begin c.cls = 4'd10; c.cost = 16'd30000; end
            default:             begin c.is_req = 1'b0; end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* sv/psfl_if.sv */
// ----------------------------------------------------------------------------
// psfl_in_if / psfl_out_if
// Valid/ready channels for packets in and verdicts out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface psfl_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic [31:0] sender_ip;
    logic [7:0]  opcode;
    logic        sender_is_lan;
    modport source (output valid, now_ms, sender_ip, opcode, sender_is_lan, input ready);
    modport sink   (input valid, now_ms, sender_ip, opcode, sender_is_lan, output ready);
endinterface

interface psfl_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;
    logic       flood_first_seen;
    logic       is_request;
    logic       table_full;
    modport source (output valid, verdict, flood_first_seen, is_request, table_full,
                    input ready);
    modport sink   (input valid, verdict, flood_first_seen, is_request, table_full,
                    output ready);
endinterface

`default_nettype wire

/* sv/psfl_ram.sv */
// ----------------------------------------------------------------------------
// psfl_ram
// Generic simple dual-port RAM, one write port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

/* sv/per_source_request_flood_limiter.sv */
// ----------------------------------------------------------------------------
// per_source_request_flood_limiter
// Token bucket per (source address, request class) with slot expiry sweep.
// ----------------------------------------------------------------------------
// One packet is handled at a time. A non-request opcode goes straight to the
// FIN state. A request scans the address slots through the slot RAM read port,
// one slot per cycle (pipelined, stops at the matching slot); when the 12
// minute sweep is due, a full pass over the slot RAM runs first. The bucket
// read-modify-write runs through the BREAD, BCALC and BEXP states.
// A finished verdict waits in an output register while the next packet starts.
// No clearing pass after reset: slot valid bits are flip-flops and each slot
// word carries the valid mask of its eleven buckets.
`timescale 1ns / 1ps
`default_nettype none

module per_source_request_flood_limiter (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cfg_we,
    input  wire logic  i_cfg_wdata,
    psfl_in_if.sink    i_in,
    psfl_out_if.source o_out
);
    localparam int SW = psfl_pkg::SLOT_W;
    localparam int CL = psfl_pkg::CLASSES;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SWEEP  = 7'b0000010,
        ST_SEARCH = 7'b0000100,
        ST_BREAD  = 7'b0001000,
        ST_BCALC  = 7'b0010000,
        ST_BEXP   = 7'b0100000,
        ST_FIN    = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic        r_lan_mode;
    logic [31:0] r_last_sweep;
    logic [psfl_pkg::SLOTS-1:0] r_slot_valid;

    logic [31:0] r_now, r_ip;
    logic        r_lan;
    psfl_pkg::t_class r_cls;

    logic [SW:0]   r_idx;
    logic          r_p_valid;
    logic [SW-1:0] r_p_idx;
    logic          r_free_found;
    logic [SW-1:0] r_free;
    logic [SW-1:0] r_slot;
    logic [psfl_pkg::SLOT_WORD_W-1:0] r_sword;

    logic signed [psfl_pkg::TOK_W-1:0] r_tok;
    logic        r_new;
    logic        r_noted;

    logic [1:0]  r_res_verdict;
    logic        r_res_first, r_res_req, r_res_full;

    logic        r_o_valid;
    logic [1:0]  r_o_verdict;
    logic        r_o_first, r_o_req, r_o_full;

    // RAMs
    logic [psfl_pkg::SLOT_WORD_W-1:0] slot_rdata, slot_wdata;
    logic                             slot_we;
    logic [psfl_pkg::BKT_WORD_W-1:0]  bkt_rdata, bkt_wdata;
    logic                             bkt_we;
    logic [psfl_pkg::BKT_AW-1:0]      bkt_addr;

    psfl_ram #(.WIDTH(psfl_pkg::SLOT_WORD_W), .DEPTH(psfl_pkg::SLOTS)) u_slot_ram (
        .i_clk  (i_clk),
        .i_we   (slot_we),
        .i_waddr(r_slot),
        .i_wdata(slot_wdata),
        .i_raddr(r_idx[SW-1:0]),
        .o_rdata(slot_rdata)
    );

    psfl_ram #(.WIDTH(psfl_pkg::BKT_WORD_W), .DEPTH(psfl_pkg::BUCKETS)) u_bkt_ram (
        .i_clk  (i_clk),
        .i_we   (bkt_we),
        .i_waddr(bkt_addr),
        .i_wdata(bkt_wdata),
        .i_raddr(bkt_addr),
        .o_rdata(bkt_rdata)
    );

    assign bkt_addr = psfl_pkg::BKT_AW'(r_slot) * psfl_pkg::BKT_AW'(CL)
                    + psfl_pkg::BKT_AW'(r_cls.cls);

    psfl_pkg::t_class in_cls;
    assign in_cls = psfl_pkg::class_of(i_in.opcode);

    assign i_in.ready = (r_state == ST_IDLE);
    logic in_acc;
    assign in_acc = i_in.valid && i_in.ready;

    logic scan_last;
    assign scan_last = r_p_valid && (r_p_idx == SW'(psfl_pkg::SLOTS - 1));

    // slot word fields of the scanned entry
    logic [31:0] sc_addr, sc_exp;
    assign sc_addr = slot_rdata[psfl_pkg::SLOT_WORD_W-1 -: 32];
    assign sc_exp  = slot_rdata[CL +: 32];

    // bucket update arithmetic
    logic [psfl_pkg::TOK_W-1:0] bk_tok;
    logic [31:0]                bk_last;
    logic                       bk_noted;
    logic signed [33:0] sum, capped, tval;
    logic [CL-1:0] bv_mask;
    logic [CL-1:0] cls_bit;
    assign {bk_tok, bk_last, bk_noted} = bkt_rdata;
    assign bv_mask = r_sword[CL-1:0];
    assign cls_bit = CL'(1) << r_cls.cls;

    always_comb begin
        sum    = $signed({{(34 - psfl_pkg::TOK_W){bk_tok[psfl_pkg::TOK_W-1]}}, bk_tok})
               + $signed({2'b00, r_now - bk_last});
        capped = (sum > psfl_pkg::TOKEN_CAP) ? psfl_pkg::TOKEN_CAP : sum;
        tval   = capped - $signed({18'd0, r_cls.cost});
        if (tval < psfl_pkg::TOKEN_FLOOR) begin
            tval = psfl_pkg::TOKEN_FLOOR;
        end
    end

    logic [psfl_pkg::TOK_W:0] mag;
    logic [31:0] exp_new, old_exp, exp_keep;
    logic signed [33:0] tok34;
    assign tok34   = 34'(r_tok);
    assign mag     = r_tok[psfl_pkg::TOK_W-1] ? (psfl_pkg::TOK_W+1)'(-tok34)
                                              : (psfl_pkg::TOK_W+1)'(tok34);
    assign old_exp = r_sword[CL +: 32];
    assign exp_new = r_now + 32'(mag) + 32'(r_cls.cost);
    assign exp_keep = (!r_new && (exp_new > old_exp)) ? exp_new : old_exp;

    logic [1:0] ex_verdict;
    logic       ex_first, ex_noted;
    always_comb begin
        ex_verdict = psfl_pkg::VERDICT_ALLOW;
        ex_first   = 1'b0;
        ex_noted   = 1'b0;
        priority if (r_new) begin
            ex_noted = 1'b0;
        end else if (r_lan_mode && r_lan) begin
            ex_noted = r_noted;
        end else if (tok34 < psfl_pkg::BAN_LEVEL) begin
            ex_verdict = psfl_pkg::VERDICT_BAN;
            ex_noted   = r_noted;
        end else if (r_tok[psfl_pkg::TOK_W-1]) begin
            ex_verdict = psfl_pkg::VERDICT_DROP;
            ex_first   = !r_noted;
            ex_noted   = 1'b1;
        end else begin
            ex_noted = 1'b0;
        end
    end

    assign slot_we    = (r_state == ST_BEXP);
    assign slot_wdata = {r_ip, exp_keep, bv_mask | cls_bit};
    assign bkt_we     = (r_state == ST_BEXP);
    assign bkt_wdata  = {r_tok, r_now, ex_noted};

    logic out_load;
    assign out_load = (r_state == ST_FIN) && (!r_o_valid || o_out.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (!in_cls.is_req) begin
                        n_state = ST_FIN;
                    end else if (i_in.now_ms >= r_last_sweep + psfl_pkg::SWEEP_PERIOD) begin
                        n_state = ST_SWEEP;
                    end else begin
                        n_state = ST_SEARCH;
                    end
                end
            end
            ST_SWEEP:  if (scan_last) n_state = ST_SEARCH;
            ST_SEARCH: begin
                if (r_p_valid && r_slot_valid[r_p_idx] && sc_addr == r_ip) begin
                    n_state = ST_BREAD;
                end else if (scan_last) begin
                    n_state = (r_free_found || !r_slot_valid[r_p_idx]) ? ST_BREAD : ST_FIN;
                end
            end
            ST_BREAD: n_state = ST_BCALC;
            ST_BCALC: n_state = ST_BEXP;
            ST_BEXP:  n_state = ST_FIN;
            ST_FIN:   if (out_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    logic scanning;
    assign scanning = (r_state == ST_SWEEP) || (r_state == ST_SEARCH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_lan_mode   <= 1'b0;
            r_last_sweep <= '0;
            r_slot_valid <= '0;
            r_idx        <= '0;
            r_p_valid    <= 1'b0;
            r_free_found <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_lan_mode <= i_cfg_wdata;
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end

            // slot scan pipeline: read issued at r_idx, checked at r_p_idx
            if (scanning && n_state == r_state && r_idx < (SW+1)'(psfl_pkg::SLOTS)) begin
                r_idx     <= r_idx + 1'b1;
                r_p_valid <= 1'b1;
            end else begin
                r_idx     <= '0;
                r_p_valid <= 1'b0;
            end

            if (in_acc) begin
                r_free_found <= 1'b0;
                if (in_cls.is_req
                    && i_in.now_ms >= r_last_sweep + psfl_pkg::SWEEP_PERIOD) begin
                    r_last_sweep <= i_in.now_ms;
                end
            end
            if (r_state == ST_SWEEP && r_p_valid && r_slot_valid[r_p_idx]
                && r_now >= sc_exp) begin
                r_slot_valid[r_p_idx] <= 1'b0;
            end
            if (r_state == ST_SEARCH && r_p_valid) begin
                if (!r_slot_valid[r_p_idx] && !r_free_found) begin
                    r_free_found <= 1'b1;
                end
                if (scan_last && !(r_slot_valid[r_p_idx] && sc_addr == r_ip)) begin
                    if (r_free_found) begin
                        r_slot_valid[r_free] <= 1'b1;
                    end else if (!r_slot_valid[r_p_idx]) begin
                        r_slot_valid[r_p_idx] <= 1'b1;
                    end
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_p_idx <= r_idx[SW-1:0];
        if (in_acc) begin
            r_now         <= i_in.now_ms;
            r_ip          <= i_in.sender_ip;
            r_lan         <= i_in.sender_is_lan;
            r_cls         <= in_cls;
            r_res_verdict <= psfl_pkg::VERDICT_ALLOW;
            r_res_first   <= 1'b0;
            r_res_req     <= in_cls.is_req;
            r_res_full    <= 1'b0;
        end
        if (r_state == ST_SEARCH && r_p_valid) begin
            if (!r_slot_valid[r_p_idx] && !r_free_found) begin
                r_free <= r_p_idx;
            end
            if (r_slot_valid[r_p_idx] && sc_addr == r_ip) begin
                r_slot  <= r_p_idx;
                r_sword <= slot_rdata;
            end else if (scan_last) begin
                // fresh slot: expiry 0, all buckets invalid
                r_slot     <= r_free_found ? r_free : r_p_idx;
                r_sword    <= {r_ip, 32'd0, {CL{1'b0}}};
                r_res_full <= !(r_free_found || !r_slot_valid[r_p_idx]);
            end
        end
        if (r_state == ST_BCALC) begin
            r_noted <= bk_noted;
            if (!bv_mask[r_cls.cls]) begin
                r_new <= 1'b1;
                r_tok <= psfl_pkg::TOK_W'(psfl_pkg::TOKEN_CAP - $signed({18'd0, r_cls.cost}));
            end else begin
                r_new <= 1'b0;
                r_tok <= tval[psfl_pkg::TOK_W-1:0];
            end
        end
        if (r_state == ST_BEXP) begin
            r_res_verdict <= ex_verdict;
            r_res_first   <= ex_first;
        end
        if (out_load) begin
            r_o_verdict <= r_res_verdict;
            r_o_first   <= r_res_first;
            r_o_req     <= r_res_req;
            r_o_full    <= r_res_full;
        end
    end

    assign o_out.valid            = r_o_valid;
    assign o_out.verdict          = r_o_verdict;
    assign o_out.flood_first_seen = r_o_first;
    assign o_out.is_request       = r_o_req;
    assign o_out.table_full       = r_o_full;

`ifndef SYNTHESIS
    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_valid |-> r_p_idx == SW'(r_idx - 1'b1))
        else $error("slot scan pipeline out of step");
    a_first_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.flood_first_seen |-> o_out.verdict == psfl_pkg::VERDICT_DROP)
        else $error("first flood flag without a drop");
    a_full_allow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.table_full
            |-> o_out.is_request && o_out.verdict == psfl_pkg::VERDICT_ALLOW)
        else $error("table full result not an allowed request");
    a_nonreq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.is_request
            |-> o_out.verdict == psfl_pkg::VERDICT_ALLOW && !o_out.flood_first_seen)
        else $error("non-request item got a flood verdict");
`endif

endmodule

`default_nettype wire
